// File: rtl/csr_ego_edge_expander_defines.svh
// Assertion macros shared by the edge expander RTL.
`ifndef CSR_EGO_EDGE_EXPANDER_DEFINES_SVH
`define CSR_EGO_EDGE_EXPANDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CEE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cee_pkg.sv
// Package for the edge expander: sizes, row type, operation codes, states.
package cee_pkg;

    // Graph sizes, fixed by the vertex and slot field widths
    localparam int unsigned VERTICES        = 1024;
    localparam int unsigned NEIGHBOUR_SLOTS = 4096;
    localparam int unsigned MAX_DEGREE_DEF  = 64;

    // Field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned VTX_W    = 10;
    localparam int unsigned SLOT_W   = 12;
    localparam int unsigned ROW_DEG_W = 7;
    localparam int unsigned NBR_W    = 10;
    localparam int unsigned POS_W    = 16;

    // Address widths of the two memories
    localparam int unsigned VTX_AW  = $clog2(VERTICES);
    localparam int unsigned SLOT_AW = $clog2(NEIGHBOUR_SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_ROW  = 2'd0,
        OP_WRITE_SLOT = 2'd1,
        OP_EXPAND     = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0]    offset;
        logic [ROW_DEG_W-1:0] degree;
    } t_row;

endpackage

// File: rtl/csr_ego_edge_expander.sv
// Edge expander top level: CSR row table, neighbour store and edge sequencer.
//
// Input channel (i_in_valid / o_in_ready) takes one word per item: a vertex
// row write, a neighbour slot write, or an expand of a center vertex. Output
// channel (o_out_valid / i_out_ready) returns one word per edge of an expand:
// (center position, neighbour id, last flag); writes return nothing.
// An expand reads the row table into a register, then streams the neighbour
// store at one slot per cycle through a one-deep read stage and the output
// register; edges follow one per cycle while the receiver takes them. The
// expand holds the input until the last store read has moved into the output
// register; a zero-degree expand frees it once the row has been read.
// The store read port sets that rate. Items are handled one at a time; the
// next item is taken while the final edge still waits in the output register.
// When the receiver stalls, the read stage and output register hold and the
// store reads stop. Reset clears the position counter and control state only;
// table and store contents are undefined until written.
module csr_ego_edge_expander #(
    parameter int unsigned MAX_DEGREE = cee_pkg::MAX_DEGREE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [cee_pkg::OP_W-1:0]      i_operation,
    input  logic [cee_pkg::VTX_W-1:0]     i_vertex,
    input  logic [cee_pkg::SLOT_W-1:0]    i_row_offset,
    input  logic [cee_pkg::ROW_DEG_W-1:0] i_row_degree,
    input  logic [cee_pkg::SLOT_W-1:0]    i_slot,
    input  logic [cee_pkg::NBR_W-1:0]     i_neighbour_value,
    input  logic                          i_batch_start,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cee_pkg::POS_W-1:0]     o_center_position,
    output logic [cee_pkg::NBR_W-1:0]     o_neighbour_id,
    output logic                          o_last_edge
);
    import cee_pkg::*;

`include "csr_ego_edge_expander_defines.svh"

    localparam int unsigned DEG_W = $clog2(MAX_DEGREE + 1);
    localparam logic [ROW_DEG_W-1:0] DegCap = ROW_DEG_W'(MAX_DEGREE);

    // Memories
    t_row              r_row_mem [VERTICES];
    logic [NBR_W-1:0]  r_nbr_mem [NEIGHBOUR_SLOTS];
    t_row              r_row_q;
    logic [NBR_W-1:0]  r_store_q;

    // Control and sequencer state
    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_batch;
    logic [SLOT_AW-1:0] r_slot;
    logic [DEG_W-1:0]   r_remain;
    logic               r_q_valid;
    logic               r_q_last;

    // Output register
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [NBR_W-1:0]   r_out_id;
    logic               r_out_last;

    logic                 w_accept;
    logic                 w_row_rd;
    logic                 w_move;
    logic                 w_issue;
    logic                 w_row_load;
    logic [ROW_DEG_W-1:0] w_deg;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_row_rd   = w_accept && (i_operation == OP_EXPAND);

    // Saturated degree of the row just read
    assign w_deg = (r_row_q.degree > DegCap) ? DegCap : r_row_q.degree;

    // Read stage moves into the output register when that register is empty or being taken
    assign w_move  = r_q_valid && (!r_out_valid || i_out_ready);
    // New store read when the read stage is empty or draining this cycle
    assign w_issue = (r_state == ST_EMIT) && (r_remain != '0) && (!r_q_valid || w_move);

    // Row table: write on a row word, registered read on an expand
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == OP_WRITE_ROW)) begin
            r_row_mem[i_vertex[VTX_AW-1:0]] <= '{offset: i_row_offset, degree: i_row_degree};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_rd) begin
            r_row_q <= r_row_mem[i_vertex[VTX_AW-1:0]];
            r_batch <= i_batch_start;
        end
    end

    // Neighbour store: write on a slot word, registered read while emitting
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_operation == OP_WRITE_SLOT)) begin
            r_nbr_mem[i_slot[SLOT_AW-1:0]] <= i_neighbour_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_store_q <= r_nbr_mem[r_slot];
            r_q_last  <= (r_remain == DEG_W'(1));
        end
    end

    // Next state and position counter
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        w_row_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_EXPAND: n_state = ST_ROW;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ROW: begin
                if (w_deg == '0) begin
                    // empty row: center still takes a position
                    n_pos   = (r_batch ? '0 : r_pos) + POS_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_pos      = r_batch ? '0 : r_pos;
                    w_row_load = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if ((r_remain == '0) && !r_q_valid) begin
                    n_pos   = r_pos + POS_W'(1);
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    // Slot walk and edge count
    always_ff @(posedge i_clk) begin
        if (w_row_load) begin
            r_slot <= r_row_q.offset[SLOT_AW-1:0];
        end else if (w_issue) begin
            r_slot <= r_slot + SLOT_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain  <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (w_row_load) begin
                r_remain <= DEG_W'(w_deg);
            end else if (w_issue) begin
                r_remain <= r_remain - DEG_W'(1);
            end
            if (w_issue) begin
                r_q_valid <= 1'b1;
            end else if (w_move) begin
                r_q_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_pos  <= r_pos;
            r_out_id   <= r_store_q;
            r_out_last <= r_q_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_center_position = r_out_pos;
    assign o_neighbour_id    = r_out_id;
    assign o_last_edge       = r_out_last;

    // Checks
    `CEE_ASSERT_NOW(a_read_stage_in_emit, i_clk, i_rst_n,
        r_q_valid, r_state == ST_EMIT, "store read data outside an expand")
    `CEE_ASSERT_NOW(a_no_work_when_ready, i_clk, i_rst_n,
        o_in_ready, (r_remain == '0) && !r_q_valid, "input ready with edges pending")
    `CEE_ASSERT_NEXT(a_pos_advance, i_clk, i_rst_n,
        (r_state == ST_EMIT) && (n_state == ST_IDLE),
        r_pos == $past(r_pos) + POS_W'(1), "position did not advance after expand")

endmodule

// File: bench/edge_scoreboard_pkg.sv
// Scoreboard for the edge expander: graph state, expected edge words, mismatch count.
package edge_scoreboard_pkg;
    import cee_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [NBR_W-1:0] nbr;
        logic             last;
    } edge_word_t;

    class edge_scoreboard;
        // shadow copy of the CSR graph and the batch position counter
        logic [SLOT_W-1:0]    offset_tbl [VERTICES];
        logic [ROW_DEG_W-1:0] degree_tbl [VERTICES];
        logic [NBR_W-1:0]     nbr_store  [NEIGHBOUR_SLOTS];
        logic [POS_W-1:0]     position;
        edge_word_t           edges_due[$];
        int                   errors;

        function new();
            position = '0;
            errors   = 0;
        endfunction

        // Apply one accepted input word; queue the edges an expand emits.
        function void note_word(logic [OP_W-1:0] op, logic [VTX_W-1:0] vertex,
                                logic [SLOT_W-1:0] off, logic [ROW_DEG_W-1:0] deg,
                                logic [SLOT_W-1:0] slot, logic [NBR_W-1:0] value,
                                logic batch_start);
            int                n;
            int                k;
            logic [SLOT_W-1:0] rd_slot;
            edge_word_t        w;
            case (op)
                OP_WRITE_ROW: begin
                    offset_tbl[vertex] = off;
                    degree_tbl[vertex] = deg;
                end
                OP_WRITE_SLOT: begin
                    nbr_store[slot] = value;
                end
                OP_EXPAND: begin
                    if (batch_start)
                        position = '0;
                    n = int'(degree_tbl[vertex]);
                    if (n > int'(MAX_DEGREE_DEF))
                        n = int'(MAX_DEGREE_DEF);
                    for (k = 0; k < n; k++) begin
                        // slot address wraps at the store size
                        rd_slot = offset_tbl[vertex] + k[SLOT_W-1:0];
                        w.pos   = position;
                        w.nbr   = nbr_store[rd_slot];
                        w.last  = (k == n - 1);
                        edges_due.push_back(w);
                    end
                    // zero-degree centers still take a position
                    position = position + 1'b1;
                end
                default: begin
                    // unused code: no effect
                end
            endcase
        endfunction

        function int open_count();
            return edges_due.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", what);
        endtask

        // Compare one accepted output word against the oldest expectation.
        task check_word(logic [POS_W-1:0] pos, logic [NBR_W-1:0] nbr, logic last);
            edge_word_t w;
            if (edges_due.size() == 0) begin
                report($sformatf("unexpected word pos=%0d nbr=%0d last=%0b", pos, nbr, last));
                return;
            end
            w = edges_due.pop_front();
            if (pos !== w.pos)
                report($sformatf("center_position %0d, want %0d", pos, w.pos));
            if (nbr !== w.nbr)
                report($sformatf("neighbour_id %0d, want %0d (pos %0d)", nbr, w.nbr, w.pos));
            if (last !== w.last)
                report($sformatf("last_edge %0b, want %0b (pos %0d)", last, w.last, w.pos));
        endtask
    endclass
endpackage

// File: bench/tb_csr_ego_edge_expander.sv
// Testbench for csr_ego_edge_expander: directed graph cases and random graphs.
module tb_csr_ego_edge_expander;
    import cee_pkg::*;
    import edge_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_WORDS = 400;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef enum {RX_FREE, RX_CHOPPY, RX_STALLS} t_rx_mode;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_in_valid        = 1'b0;
    logic [OP_W-1:0]      i_operation       = '0;
    logic [VTX_W-1:0]     i_vertex          = '0;
    logic [SLOT_W-1:0]    i_row_offset      = '0;
    logic [ROW_DEG_W-1:0] i_row_degree      = '0;
    logic [SLOT_W-1:0]    i_slot            = '0;
    logic [NBR_W-1:0]     i_neighbour_value = '0;
    logic                 i_batch_start     = 1'b0;
    logic                 i_out_ready       = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [POS_W-1:0]     o_center_position;
    logic [NBR_W-1:0]     o_neighbour_id;
    logic                 o_last_edge;

    edge_scoreboard   sb;
    int               cycle_count = 0;
    int               word_count  = 0;
    int               burst_left  = 0;
    bit               row_ok  [VERTICES];
    bit               slot_ok [NEIGHBOUR_SLOTS];
    logic [VTX_W-1:0] row_list[$];
    t_rx_mode         rx_mode     = RX_FREE;
    int               rx_left     = 0;
    int               stall_left  = 0;

    csr_ego_edge_expander dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_vertex          (i_vertex),
        .i_row_offset      (i_row_offset),
        .i_row_degree      (i_row_degree),
        .i_slot            (i_slot),
        .i_neighbour_value (i_neighbour_value),
        .i_batch_start     (i_batch_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_center_position (o_center_position),
        .o_neighbour_id    (o_neighbour_id),
        .o_last_edge       (o_last_edge)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_csr_ego_edge_expander NOT OK");
            $finish;
        end
    end

    // receiver: free-running, choppy, or long stall runs, switched at random
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE: begin
                i_out_ready <= 1'b1;
            end
            RX_CHOPPY: begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_ready <= 1'b0;
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = $urandom_range(1, 7);
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        endcase
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_center_position, o_neighbour_id, o_last_edge);
    end

    // Drive one word in bursts with random gaps; returns at the falling edge after acceptance.
    task automatic send_word(logic [OP_W-1:0] op, logic [VTX_W-1:0] vertex,
                             logic [SLOT_W-1:0] off, logic [ROW_DEG_W-1:0] deg,
                             logic [SLOT_W-1:0] slot, logic [NBR_W-1:0] value,
                             logic batch_start);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_vertex          <= vertex;
        i_row_offset      <= off;
        i_row_degree      <= deg;
        i_slot            <= slot;
        i_neighbour_value <= value;
        i_batch_start     <= batch_start;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(op, vertex, off, deg, slot, value, batch_start);
        if (op != OP_RESERVED)
            word_count++;
        if (op == OP_WRITE_ROW) begin
            if (!row_ok[vertex])
                row_list.push_back(vertex);
            row_ok[vertex] = 1'b1;
        end
        if (op == OP_WRITE_SLOT)
            slot_ok[slot] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic write_row(logic [VTX_W-1:0] v, logic [SLOT_W-1:0] off,
                             logic [ROW_DEG_W-1:0] deg);
        send_word(OP_WRITE_ROW, v, off, deg, SLOT_W'($urandom), NBR_W'($urandom),
                  1'($urandom));
    endtask

    task automatic write_slot(logic [SLOT_W-1:0] s, logic [NBR_W-1:0] value);
        send_word(OP_WRITE_SLOT, VTX_W'($urandom), SLOT_W'($urandom),
                  ROW_DEG_W'($urandom), s, value, 1'($urandom));
    endtask

    task automatic expand_center(logic [VTX_W-1:0] v, logic batch_start);
        send_word(OP_EXPAND, v, SLOT_W'($urandom), ROW_DEG_W'($urandom),
                  SLOT_W'($urandom), NBR_W'($urandom), batch_start);
    endtask

    // Hold the input idle until every expected edge has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (sb.open_count() != 0);
    endtask

    // A center may be expanded only if its row and every slot it reads were written.
    function automatic bit readable(logic [VTX_W-1:0] v);
        int                n;
        int                k;
        logic [SLOT_W-1:0] s;
        if (!row_ok[v])
            return 1'b0;
        n = int'(sb.degree_tbl[v]);
        if (n > int'(MAX_DEGREE_DEF))
            n = int'(MAX_DEGREE_DEF);
        for (k = 0; k < n; k++) begin
            s = sb.offset_tbl[v] + k[SLOT_W-1:0];
            if (!slot_ok[s])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly small degrees, a few past the saturation point
    function automatic logic [ROW_DEG_W-1:0] pick_degree();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return ROW_DEG_W'($urandom_range(0, 6));
        else if (r < 95)
            return ROW_DEG_W'($urandom_range(7, 24));
        return ROW_DEG_W'($urandom_range(25, 127));
    endfunction

    // Well-formed sequence: row, its slots, then one or two expands.
    task automatic build_center(logic [VTX_W-1:0] v, logic [SLOT_W-1:0] off,
                                logic [ROW_DEG_W-1:0] deg);
        int n;
        int k;
        int reps;
        n = int'(deg);
        if (n > int'(MAX_DEGREE_DEF))
            n = int'(MAX_DEGREE_DEF);
        write_row(v, off, deg);
        for (k = 0; k < n; k++)
            write_slot(off + k[SLOT_W-1:0], NBR_W'($urandom));
        reps = $urandom_range(1, 2);
        repeat (reps) expand_center(v, ($urandom_range(0, 3) == 0));
    endtask

    initial begin
        int               pick;
        int               stop_at;
        bit               mid_drained;
        logic [VTX_W-1:0] v;

        sb = new();
        mid_drained = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: slot wrap, extremes, zero degree, unused code, batch restarts
        send_word(OP_WRITE_ROW, 10'd0, 12'd4094, 7'd3, 12'd4095, 10'd1023, 1'b1);
        write_slot(12'd4094, 10'd1023);
        write_slot(12'd4095, 10'd0);
        write_slot(12'd0, 10'h2AA);
        expand_center(10'd0, 1'b1);
        write_row(10'd1023, 12'd4095, 7'd0);
        expand_center(10'd1023, 1'b0);
        send_word(OP_RESERVED, 10'h3FF, 12'hFFF, 7'h7F, 12'hFFF, 10'h3FF, 1'b1);
        send_word(OP_RESERVED, 10'd0, 12'd0, 7'd0, 12'd0, 10'd0, 1'b0);
        expand_center(10'd0, 1'b0);
        write_row(10'd512, 12'd0, 7'd1);
        write_slot(12'd0, 10'h155);
        expand_center(10'd512, 1'b1);
        write_row(10'd0, 12'd4095, 7'd2);
        expand_center(10'd0, 1'b0);
        expand_center(10'd1023, 1'b1);
        expand_center(10'd512, 1'b0);
        wait_drained();

        // random graphs; first two rows exercise degree saturation
        stop_at = word_count + RANDOM_WORDS;
        build_center(VTX_W'($urandom), SLOT_W'($urandom), 7'd127);
        build_center(VTX_W'($urandom), SLOT_W'($urandom), 7'd64);
        while (word_count < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                build_center(VTX_W'($urandom), SLOT_W'($urandom), pick_degree());
            end else if (pick < 75) begin
                v = row_list[$urandom_range(0, row_list.size() - 1)];
                if (readable(v))
                    expand_center(v, ($urandom_range(0, 3) == 0));
            end else if (pick < 85) begin
                write_slot(SLOT_W'($urandom), NBR_W'($urandom));
            end else if (pick < 92) begin
                // row with no slots behind it: not expanded until they exist
                write_row(VTX_W'($urandom), SLOT_W'($urandom), pick_degree());
            end else begin
                send_word(OP_RESERVED, VTX_W'($urandom), SLOT_W'($urandom),
                          ROW_DEG_W'($urandom), SLOT_W'($urandom), NBR_W'($urandom),
                          1'($urandom));
            end
            if (!mid_drained && word_count >= stop_at - RANDOM_WORDS / 2) begin
                mid_drained = 1'b1;
                wait_drained();
            end
        end

        // drain and let any stray words show up
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_csr_ego_edge_expander OK");
        else
            $display("tb_csr_ego_edge_expander NOT OK");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/cee_pkg.sv
rtl/csr_ego_edge_expander.sv
bench/edge_scoreboard_pkg.sv
bench/tb_csr_ego_edge_expander.sv
